// ----- hdl/camera_basis_rebuild_defines.svh -----
// ----------------------------------------------------------------------------
// Camera basis rebuild assertion macros
// Shared property wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef CAMERA_BASIS_REBUILD_DEFINES_SVH
`define CAMERA_BASIS_REBUILD_DEFINES_SVH

// Property checked outside reset only.
`define CBR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define CBR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/cbr_pkg.sv -----
// ----------------------------------------------------------------------------
// Camera basis rebuild package
// Shared types and constants of the camera basis rebuild block.
// ----------------------------------------------------------------------------
package cbr_pkg;

	// Handshake status of an iterative unit.
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	localparam int SQ_IN_W  = 64;
	localparam int SQ_OUT_W = 32;
	localparam int DEN_W    = 32;

	localparam logic [1:0] CMD_TRANSLATE = 2'd0;
	localparam logic [1:0] CMD_SET_POS   = 2'd1;
	localparam logic [1:0] CMD_SET_TGT   = 2'd2;

	// Result tuser layout.
	localparam int USER_DROP_BIT = 0;
	localparam int USER_FLAG_LO  = 1;
	localparam int USER_FLAG_HI  = 5;

	localparam int FLG_UP_ZERO  = 0;
	localparam int FLG_POS_EQ   = 1;
	localparam int FLG_FWD_KEEP = 2;
	localparam int FLG_UP_DEF   = 3;
	localparam int FLG_UP_SIDE  = 4;

endpackage

// ----- hdl/cbr_sqrt.sv -----
// ----------------------------------------------------------------------------
// Camera basis rebuild square root
// Bit-serial floor square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module cbr_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [cbr_pkg::SQ_IN_W-1:0]   x,
	output logic [cbr_pkg::SQ_OUT_W-1:0]  root,
	output cbr_pkg::unit_stat_t           stat
);

	logic [cbr_pkg::SQ_IN_W-1:0]  x_q;
	logic [33:0]                  rem_q;
	logic [cbr_pkg::SQ_OUT_W-1:0] root_q;
	logic [5:0]                   cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic [35:0]                  rem_sh;
	logic [35:0]                  trial;
	logic                         ge;

	assign rem_sh = {rem_q, x_q[cbr_pkg::SQ_IN_W-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				x_q    <= x;
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= 6'(cbr_pkg::SQ_OUT_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q  <= ge ? 34'(rem_sh - trial) : 34'(rem_sh);
				root_q <= {root_q[cbr_pkg::SQ_OUT_W-2:0], ge};
				x_q    <= {x_q[cbr_pkg::SQ_IN_W-3:0], 2'b00};
				cnt_q  <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign root      = root_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ----- hdl/cbr_div.sv -----
// ----------------------------------------------------------------------------
// Camera basis rebuild divider
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cbr_div #(
	parameter int NW = 48
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [NW-1:0]               num,
	input  logic [cbr_pkg::DEN_W-1:0]   den,
	output logic [NW-1:0]               quot,
	output cbr_pkg::unit_stat_t         stat
);

	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0]             num_q;
	logic [NW-1:0]             quo_q;
	logic [cbr_pkg::DEN_W-1:0] den_q;
	logic [cbr_pkg::DEN_W-1:0] rem_q;
	logic [CW-1:0]             cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [cbr_pkg::DEN_W:0]   rem_sh;
	logic                      ge;

	assign rem_sh = {rem_q, num_q[NW-1]};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				num_q  <= num;
				den_q  <= den;
				rem_q  <= '0;
				quo_q  <= '0;
				cnt_q  <= CW'(NW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? cbr_pkg::DEN_W'(rem_sh - {1'b0, den_q})
					: cbr_pkg::DEN_W'(rem_sh);
				quo_q <= {quo_q[NW-2:0], ge};
				num_q <= {num_q[NW-2:0], 1'b0};
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quot      = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ----- hdl/camera_basis_rebuild.sv -----
// ----------------------------------------------------------------------------
// Camera basis rebuild
// Look-at camera that rebuilds an orthonormal basis after every request that is not dropped.
// ----------------------------------------------------------------------------
// Each request runs three normalizes and two cross products, or five normalizes and four
// cross products on the up fallbacks; a normalize of zero length skips its divides.
// One request at a time: no new request is taken until the last result is loaded.
// A dropped request goes straight to the done state. A waiting result does not block intake.
// Asynchronous reset restores the default camera and length threshold 7.
module camera_basis_rebuild #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [103:0] s_tdata,   // cmd, vec_x, vec_y, vec_z, zero fill
	input  logic         s_tuser,   // not_finite
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [167:0] m_tdata,   // fwd_x..z, right_x..z, upv_x..z, zero fill
	output logic [5:0]   m_tuser    // dropped, fallback_flags
);

	localparam int UW  = FRAC_BITS + 2;
	localparam int NVW = 34;
	localparam int DW  = 32 + FRAC_BITS;
	localparam logic signed [UW-1:0]  ONE_U  = UW'(1) << FRAC_BITS;
	localparam logic signed [31:0]    POS_Z  = 32'(5) << FRAC_BITS;
	localparam logic signed [33:0]    SAT_HI = 34'sd2147483647;
	localparam logic signed [33:0]    SAT_LO = -34'sd2147483648;
	localparam logic [DW-1:0]         ONE_Q  = DW'(1) << FRAC_BITS;

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b00000000001,
		ST_FIX    = 11'b00000000010,
		ST_DIFF   = 11'b00000000100,
		ST_CROSS  = 11'b00000001000,
		ST_NMAG   = 11'b00000010000,
		ST_NSQ    = 11'b00000100000,
		ST_NSQRT  = 11'b00001000000,
		ST_NDIV   = 11'b00010000000,
		ST_NDWAIT = 11'b00100000000,
		ST_POST   = 11'b01000000000,
		ST_DONE   = 11'b10000000000
	} state_t;

	typedef enum logic [4:0] {
		RET_FWD = 5'b00001,
		RET_RGT = 5'b00010,
		RET_ALT = 5'b00100,
		RET_FIX = 5'b01000,
		RET_UP  = 5'b10000
	} ret_t;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		if (v > SAT_HI) return 32'sh7fffffff;
		if (v < SAT_LO) return 32'sh80000000;
		return 32'(v);
	endfunction

	function automatic logic signed [NVW-1:0] rnd(input logic signed [63:0] v);
		logic [63:0] m;
		logic [63:0] r;
		m = v[63] ? unsigned'(-v) : unsigned'(v);
		r = (m + (64'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		return v[63] ? -NVW'(r) : NVW'(r);
	endfunction

	function automatic logic [NVW-1:0] mag(input logic signed [NVW-1:0] v);
		return v[NVW-1] ? unsigned'(-v) : unsigned'(v);
	endfunction

	function automatic logic [17:0] out18(input logic signed [UW-1:0] v);
		return 18'(v);
	endfunction

	state_t state_q;
	ret_t   ret_q;
	logic [2:0]  cnt_q;
	logic [15:0] eps_q;
	logic        mv_q;
	logic [167:0] mdata_q;
	logic [5:0]   muser_q;

	logic signed [31:0] pos_q [3];
	logic signed [31:0] tgt_q [3];
	logic signed [UW-1:0] up_q  [3];
	logic signed [UW-1:0] fwd_q [3];
	logic signed [UW-1:0] rgt_q [3];
	logic [4:0] flags_q;
	logic       drop_q;

	logic signed [NVW-1:0] nv_q [3];
	logic signed [UW-1:0]  xa_q [3];
	logic signed [UW-1:0]  xb_q [3];
	logic signed [UW-1:0]  u_q  [3];
	logic [30:0]           a_q  [3];
	logic [2:0]            neg_q;
	logic                  s_q;
	logic [63:0]           sum_q;
	logic signed [63:0]    acc_q;
	logic signed [63:0]    prod_q;
	logic [31:0]           ls_q;
	logic [32:0]           len_q;

	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic [1:0]         in_cmd;
	logic signed [31:0] in_v [3];
	logic [NVW-1:0]     mg [3];
	logic [NVW-1:0]     mmax;
	logic               sh;
	logic [30:0]        a_sel;
	logic               neg_sel;
	logic               len_short;
	logic               up_zero;
	logic               pos_eq;
	logic               m_load;

	logic                sq_start;
	logic [63:0]         sq_x;
	logic [31:0]         sq_root;
	cbr_pkg::unit_stat_t sq_stat;
	logic                dv_start;
	logic [DW-1:0]       dv_num;
	logic [DW-1:0]       dv_quot;
	logic [DW-1:0]       dv_clamp;
	logic [UW-1:0]       dv_u;
	cbr_pkg::unit_stat_t dv_stat;

	assign in_cmd  = s_tdata[1:0];
	assign in_v[0] = s_tdata[33:2];
	assign in_v[1] = s_tdata[65:34];
	assign in_v[2] = s_tdata[97:66];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mg[i] = mag(nv_q[i]);
		end
		mmax = (mg[0] > mg[1]) ? mg[0] : mg[1];
		if (mg[2] > mmax) begin
			mmax = mg[2];
		end
	end
	// All components are halved before squaring when any is at or above 2^31.
	assign sh = |mmax[NVW-1:31];

	always_comb begin
		case (cnt_q)
			3'd1: begin
				a_sel   = a_q[1];
				neg_sel = neg_q[1];
			end
			3'd2: begin
				a_sel   = a_q[2];
				neg_sel = neg_q[2];
			end
			default: begin
				a_sel   = a_q[0];
				neg_sel = neg_q[0];
			end
		endcase
	end

	// One shared multiplier: squares during normalize, cross terms otherwise.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_NSQ) begin
			mul_a = signed'(32'(a_sel));
			mul_b = signed'(32'(a_sel));
		end else begin
			case (cnt_q)
				3'd0: begin
					mul_a = 32'(xa_q[1]);
					mul_b = 32'(xb_q[2]);
				end
				3'd1: begin
					mul_a = 32'(xa_q[2]);
					mul_b = 32'(xb_q[1]);
				end
				3'd2: begin
					mul_a = 32'(xa_q[2]);
					mul_b = 32'(xb_q[0]);
				end
				3'd3: begin
					mul_a = 32'(xa_q[0]);
					mul_b = 32'(xb_q[2]);
				end
				3'd4: begin
					mul_a = 32'(xa_q[0]);
					mul_b = 32'(xb_q[1]);
				end
				3'd5: begin
					mul_a = 32'(xa_q[1]);
					mul_b = 32'(xb_q[0]);
				end
				default: begin
					mul_a = '0;
					mul_b = '0;
				end
			endcase
		end
	end

	assign sq_x     = sum_q + unsigned'(prod_q);
	assign sq_start = (state_q == ST_NSQ) && (cnt_q == 3'd3);
	assign dv_num   = (DW'(a_sel) << FRAC_BITS) + DW'(ls_q >> 1);
	assign dv_start = (state_q == ST_NDIV) && (ls_q != '0);
	assign dv_clamp = (dv_quot > ONE_Q) ? ONE_Q : dv_quot;
	assign dv_u     = neg_sel ? -UW'(dv_clamp) : UW'(dv_clamp);

	assign len_short = len_q < 33'(eps_q);
	assign up_zero   = (up_q[0] == '0) && (up_q[1] == '0) && (up_q[2] == '0);
	assign pos_eq    = (pos_q[0] == tgt_q[0]) && (pos_q[1] == tgt_q[1])
		&& (pos_q[2] == tgt_q[2]);
	assign m_load    = (state_q == ST_DONE) && (!mv_q || m_tready);

	cbr_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.x      (sq_x),
		.root   (sq_root),
		.stat   (sq_stat)
	);

	cbr_div #(.NW(DW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_start),
		.num    (dv_num),
		.den    (ls_q),
		.quot   (dv_quot),
		.stat   (dv_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= RET_FWD;
			cnt_q   <= '0;
			eps_q   <= 16'd7;
			mv_q    <= 1'b0;
			pos_q   <= '{32'sd0, 32'sd0, POS_Z};
			tgt_q   <= '{32'sd0, 32'sd0, 32'sd0};
			up_q    <= '{'0, ONE_U, '0};
			fwd_q   <= '{'0, '0, -ONE_U};
			rgt_q   <= '{ONE_U, '0, '0};
			flags_q <= '0;
			drop_q  <= 1'b0;
		end else begin
			prod_q <= mul_a * mul_b;
			if (cfg_we) begin
				eps_q <= cfg_wdata;
			end
			if (m_load) begin
				mv_q <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				mv_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						flags_q <= '0;
						drop_q  <= s_tuser;
						if (s_tuser) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_FIX;
							for (int i = 0; i < 3; i++) begin
								case (in_cmd)
									cbr_pkg::CMD_TRANSLATE: begin
										pos_q[i] <= sat32(34'(pos_q[i]) + 34'(in_v[i]));
										tgt_q[i] <= sat32(34'(tgt_q[i]) + 34'(in_v[i]));
									end
									cbr_pkg::CMD_SET_POS: begin
										pos_q[i] <= in_v[i];
										tgt_q[i] <= sat32(34'(tgt_q[i]) + 34'(in_v[i])
											- 34'(pos_q[i]));
									end
									cbr_pkg::CMD_SET_TGT: begin
										tgt_q[i] <= in_v[i];
									end
									default: begin
									end
								endcase
							end
						end
					end
				end
				ST_FIX: begin
					if (up_zero) begin
						up_q <= '{'0, ONE_U, '0};
						flags_q[cbr_pkg::FLG_UP_ZERO] <= 1'b1;
					end
					if (pos_eq) begin
						pos_q <= '{32'sd0, 32'sd0, POS_Z};
						tgt_q <= '{32'sd0, 32'sd0, 32'sd0};
						flags_q[cbr_pkg::FLG_POS_EQ] <= 1'b1;
					end
					state_q <= ST_DIFF;
				end
				ST_DIFF: begin
					for (int i = 0; i < 3; i++) begin
						nv_q[i] <= NVW'(tgt_q[i]) - NVW'(pos_q[i]);
					end
					ret_q   <= RET_FWD;
					state_q <= ST_NMAG;
				end
				ST_CROSS: begin
					// Odd counts latch the first term, even counts close a component.
					case (cnt_q)
						3'd1, 3'd3, 3'd5: acc_q <= prod_q;
						3'd2: nv_q[0] <= rnd(acc_q - prod_q);
						3'd4: nv_q[1] <= rnd(acc_q - prod_q);
						3'd6: nv_q[2] <= rnd(acc_q - prod_q);
						default: begin
						end
					endcase
					if (cnt_q == 3'd6) begin
						cnt_q   <= '0;
						state_q <= ST_NMAG;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				ST_NMAG: begin
					for (int i = 0; i < 3; i++) begin
						a_q[i]   <= sh ? 31'(mg[i] >> 1) : 31'(mg[i]);
						neg_q[i] <= nv_q[i][NVW-1];
					end
					s_q     <= sh;
					sum_q   <= '0;
					cnt_q   <= '0;
					state_q <= ST_NSQ;
				end
				ST_NSQ: begin
					if (cnt_q == 3'd1 || cnt_q == 3'd2) begin
						sum_q <= sq_x;
					end
					if (cnt_q == 3'd3) begin
						cnt_q   <= '0;
						state_q <= ST_NSQRT;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				ST_NSQRT: begin
					if (sq_stat.done) begin
						ls_q    <= sq_root;
						len_q   <= s_q ? {sq_root, 1'b0} : {1'b0, sq_root};
						cnt_q   <= '0;
						state_q <= ST_NDIV;
					end
				end
				ST_NDIV: begin
					if (ls_q == '0) begin
						u_q[cnt_q[1:0]] <= '0;
						if (cnt_q == 3'd2) begin
							cnt_q   <= '0;
							state_q <= ST_POST;
						end else begin
							cnt_q <= cnt_q + 3'd1;
						end
					end else begin
						state_q <= ST_NDWAIT;
					end
				end
				ST_NDWAIT: begin
					if (dv_stat.done) begin
						u_q[cnt_q[1:0]] <= dv_u;
						if (cnt_q == 3'd2) begin
							cnt_q   <= '0;
							state_q <= ST_POST;
						end else begin
							cnt_q   <= cnt_q + 3'd1;
							state_q <= ST_NDIV;
						end
					end
				end
				ST_POST: begin
					cnt_q   <= '0;
					state_q <= ST_CROSS;
					case (ret_q)
						RET_FWD: begin
							if (len_short) begin
								flags_q[cbr_pkg::FLG_FWD_KEEP] <= 1'b1;
								xa_q <= fwd_q;
							end else begin
								fwd_q <= u_q;
								xa_q  <= u_q;
							end
							xb_q  <= up_q;
							ret_q <= RET_RGT;
						end
						RET_RGT: begin
							if (len_short) begin
								xa_q  <= fwd_q;
								xb_q  <= '{'0, ONE_U, '0};
								ret_q <= RET_ALT;
							end else begin
								rgt_q <= u_q;
								xa_q  <= u_q;
								xb_q  <= fwd_q;
								ret_q <= RET_UP;
							end
						end
						RET_ALT: begin
							// If forward lies along the default up as well, use the side axis; else use the default up.
							if (len_short) begin
								up_q <= '{ONE_U, '0, '0};
								xb_q <= '{ONE_U, '0, '0};
								flags_q[cbr_pkg::FLG_UP_SIDE] <= 1'b1;
							end else begin
								up_q <= '{'0, ONE_U, '0};
								xb_q <= '{'0, ONE_U, '0};
								flags_q[cbr_pkg::FLG_UP_DEF] <= 1'b1;
							end
							xa_q  <= fwd_q;
							ret_q <= RET_FIX;
						end
						RET_FIX: begin
							rgt_q <= u_q;
							xa_q  <= u_q;
							xb_q  <= fwd_q;
							ret_q <= RET_UP;
						end
						RET_UP: begin
							up_q    <= u_q;
							state_q <= ST_DONE;
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_DONE: begin
					if (m_load) begin
						mdata_q <= {6'b0,
							out18(up_q[2]), out18(up_q[1]), out18(up_q[0]),
							out18(rgt_q[2]), out18(rgt_q[1]), out18(rgt_q[0]),
							out18(fwd_q[2]), out18(fwd_q[1]), out18(fwd_q[0])};
						muser_q <= {flags_q, drop_q};
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = mv_q;
	assign m_tdata  = mdata_q;
	assign m_tuser  = muser_q;

endmodule

// ----- hdl/cbr_checker.sv -----
// ----------------------------------------------------------------------------
// Camera basis rebuild checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "camera_basis_rebuild_defines.svh"

module cbr_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         cfg_we,
	input logic [15:0]  cfg_wdata,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [103:0] s_tdata,
	input logic         s_tuser,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [167:0] m_tdata,
	input logic [5:0]   m_tuser
);

	`CBR_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !m_tvalid, "result valid during reset")
	`CBR_ASSERT(a_result_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
	`CBR_ASSERT(a_one_at_a_time, clk, arst_n, s_tvalid && s_tready |=> !s_tready, "request taken while busy")
	`CBR_ASSERT(a_drop_no_flags, clk, arst_n, m_tvalid && m_tuser[cbr_pkg::USER_DROP_BIT] |-> m_tuser[cbr_pkg::USER_FLAG_HI:cbr_pkg::USER_FLAG_LO] == '0, "dropped request reports fallbacks")

endmodule

bind camera_basis_rebuild cbr_checker u_cbr_checker (.*);
